// ----- rtl/core/arp_resolution_engine_core_macros.svh -----
// ----------------------------------------------------------------------------
// arp resolution engine core assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ARP_RESOLUTION_ENGINE_CORE_MACROS_SVH
`define ARP_RESOLUTION_ENGINE_CORE_MACROS_SVH

`ifndef SYNTH
`define ARPRE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("arpre assertion failed");
`define ARPRE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("arpre assertion failed");
`else
`define ARPRE_ASSERT_IMP(lbl, ante, cons)
`define ARPRE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/arpre_pkg.sv -----
// ----------------------------------------------------------------------------
// arpre_pkg
// shared constants, codes and transaction types of the arp resolution engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arpre_pkg;

   localparam int CACHE_ENTRIES   = 16;
   localparam int PENDING_ENTRIES = 8;
   localparam int WAIT_DEPTH      = 16;

   localparam int CACHE_AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int PEND_AW  = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
   localparam int WAIT_AW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int WAIT_CW  = $clog2(WAIT_DEPTH + 1);
   localparam int IDX_W0   = (CACHE_AW > PEND_AW) ? CACHE_AW : PEND_AW;
   localparam int IDX_W    = (IDX_W0 > WAIT_AW) ? IDX_W0 : WAIT_AW;
   localparam int CNT_W    = ((IDX_W > WAIT_CW) ? IDX_W : WAIT_CW) + 1;

   localparam int MAC_W    = 48;
   localparam int IP_W     = 32;
   localparam int TTL_W    = 20;
   localparam int HANDLE_W = 16;
   localparam int EL_W     = 16;
   localparam int OPC_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic [1:0] OP_SEND    = 2'd0;
   localparam logic [1:0] OP_RECEIVE = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam logic [1:0] KIND_ARP_REQUEST = 2'd0;
   localparam logic [1:0] KIND_ARP_REPLY   = 2'd1;
   localparam logic [1:0] KIND_IPV4_OUT    = 2'd2;
   localparam logic [1:0] KIND_DELIVER     = 2'd3;

   localparam logic [1:0] FTYPE_IPV4 = 2'd0;
   localparam logic [1:0] FTYPE_ARP  = 2'd1;

   localparam logic [OPC_W-1:0] ARP_OP_REQUEST = 16'd1;
   localparam logic [OPC_W-1:0] ARP_OP_REPLY   = 16'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFETIME = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY    = 2'd3;

   localparam logic [TTL_W-1:0] LIFETIME_RESET = 20'd30000;
   localparam logic [TTL_W-1:0] RETRY_RESET    = 20'd5000;
   localparam logic [MAC_W-1:0] BCAST_MAC      = {MAC_W{1'b1}};

   typedef struct packed {
      logic [1:0]          op;
      logic [IP_W-1:0]     hop_ip;
      logic [HANDLE_W-1:0] dgram_handle;
      logic [MAC_W-1:0]    frame_dst_mac;
      logic [1:0]          frame_type;
      logic                parse_ok;
      logic [OPC_W-1:0]    arp_opcode;
      logic [MAC_W-1:0]    arp_sender_mac;
      logic [IP_W-1:0]     arp_sender_ip;
      logic [IP_W-1:0]     arp_target_ip;
      logic [EL_W-1:0]     elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]          out_kind;
      logic [MAC_W-1:0]    dst_mac;
      logic [MAC_W-1:0]    arp_target_mac;
      logic [IP_W-1:0]     arp_target_ip_out;
      logic [HANDLE_W-1:0] dgram_out;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
      logic [TTL_W-1:0] ttl;
   } cache_ent_type;

   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [TTL_W-1:0] timer;
   } pend_ent_type;

   typedef struct packed {
      logic [IP_W-1:0]     ip;
      logic [HANDLE_W-1:0] handle;
   } wait_ent_type;

endpackage

// ----- rtl/core/arp_resolution_engine_core.sv -----
// ----------------------------------------------------------------------------
// arp_resolution_engine_core
// arp cache, pending request table and waiting datagram queue in rams,
// walked by a sequencer one entry at a time through read and update cycles
// ----------------------------------------------------------------------------
//  channel  | ports                        | direction
//  req      | req_valid/req_ready/req_data | in, one item per transaction
//  rsp      | rsp_valid/rsp_ready/rsp_data | out, up to 17 per item
//  csr      | csr_wr_en/csr_index/csr_wdata| in, write only
//
//  each table entry visited has a ram read phase, then an update phase
//  one item at a time; the next item is taken once the last result is staged
//  a stalled rsp channel halts the walk at the next result
//  synchronous reset clears valid bits, queue count and control, no ram pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "arp_resolution_engine_core_macros.svh"

module arp_resolution_engine_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  arpre_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output arpre_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [arpre_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [arpre_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_DEC     = 4'd1;
   localparam logic [3:0] ST_S_CSCAN = 4'd2;
   localparam logic [3:0] ST_S_PSCAN = 4'd3;
   localparam logic [3:0] ST_S_ALLOC = 4'd4;
   localparam logic [3:0] ST_L_CSCAN = 4'd5;
   localparam logic [3:0] ST_L_CWR   = 4'd6;
   localparam logic [3:0] ST_F_WSCAN = 4'd7;
   localparam logic [3:0] ST_F_PCLR  = 4'd8;
   localparam logic [3:0] ST_T_CSCAN = 4'd9;
   localparam logic [3:0] ST_T_PSCAN = 4'd10;
   localparam logic [3:0] ST_FINISH  = 4'd11;

   localparam int CACHE_W = $bits(arpre_pkg::cache_ent_type);
   localparam int PEND_W  = $bits(arpre_pkg::pend_ent_type);
   localparam int WAIT_W  = $bits(arpre_pkg::wait_ent_type);

   localparam logic [arpre_pkg::IDX_W-1:0] CACHE_LAST =
      arpre_pkg::IDX_W'(arpre_pkg::CACHE_ENTRIES - 1);
   localparam logic [arpre_pkg::IDX_W-1:0] PEND_LAST =
      arpre_pkg::IDX_W'(arpre_pkg::PENDING_ENTRIES - 1);
   localparam logic [arpre_pkg::WAIT_CW-1:0] WAIT_FULL =
      arpre_pkg::WAIT_CW'(arpre_pkg::WAIT_DEPTH);

   // configuration
   logic [arpre_pkg::MAC_W-1:0] own_mac_ff;
   logic [arpre_pkg::IP_W-1:0]  own_ip_ff;
   logic [arpre_pkg::TTL_W-1:0] lifetime_ff;
   logic [arpre_pkg::TTL_W-1:0] retry_ff;

   // control
   logic [3:0]                        state_ff, state_in;
   logic [arpre_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic                              phase_ff, phase_in;
   arpre_pkg::req_type                item_ff;
   logic                              item_load;
   logic                              match_ff, match_in;
   logic [arpre_pkg::CACHE_AW-1:0]    match_idx_ff, match_idx_in;
   logic [arpre_pkg::TTL_W-1:0]       min_ttl_ff, min_ttl_in;
   logic [arpre_pkg::CACHE_AW-1:0]    min_idx_ff, min_idx_in;
   logic [arpre_pkg::WAIT_CW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [arpre_pkg::WAIT_CW-1:0]     wait_cnt_ff, wait_cnt_in;
   logic [arpre_pkg::CACHE_ENTRIES-1:0]   cache_vld_ff, cache_vld_in;
   logic [arpre_pkg::PENDING_ENTRIES-1:0] pend_vld_ff, pend_vld_in;

   // result staging: one held result plus the output register
   logic                hold_vld_ff;
   arpre_pkg::rsp_type  hold_ff;
   logic                rsp_valid_ff;
   arpre_pkg::rsp_type  rsp_data_ff;
   logic                emit_en;
   arpre_pkg::rsp_type  emit_data;
   logic                fin_push;
   logic                can_emit;
   arpre_pkg::rsp_type  push_data;

   // ram ports
   logic                           c_we, p_we, w_we;
   logic [arpre_pkg::CACHE_AW-1:0] c_waddr, c_raddr;
   logic [arpre_pkg::PEND_AW-1:0]  p_waddr, p_raddr;
   logic [arpre_pkg::WAIT_AW-1:0]  w_waddr, w_raddr;
   arpre_pkg::cache_ent_type       c_wdata, c_rd;
   arpre_pkg::pend_ent_type        p_wdata, p_rd;
   arpre_pkg::wait_ent_type        w_wdata, w_rd;
   logic [CACHE_W-1:0]             c_rd_bits;
   logic [PEND_W-1:0]              p_rd_bits;
   logic [WAIT_W-1:0]              w_rd_bits;

   // free slot search
   logic                           cfree_vld;
   logic [arpre_pkg::CACHE_AW-1:0] cfree_idx;
   logic                           pfree_vld;
   logic [arpre_pkg::PEND_AW-1:0]  pfree_idx;

   logic [arpre_pkg::TTL_W-1:0]    el_ext;
   logic                           dst_ok;
   logic                           is_req;
   logic                           wait_end;

   assign c_raddr = idx_ff[arpre_pkg::CACHE_AW-1:0];
   assign p_raddr = idx_ff[arpre_pkg::PEND_AW-1:0];
   assign w_raddr = idx_ff[arpre_pkg::WAIT_AW-1:0];
   assign c_rd = c_rd_bits;
   assign p_rd = p_rd_bits;
   assign w_rd = w_rd_bits;

   arpre_ram #(.WIDTH(CACHE_W), .DEPTH(arpre_pkg::CACHE_ENTRIES), .AW(arpre_pkg::CACHE_AW))
   u_cache_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (c_raddr),
      .rd_data (c_rd_bits)
   );

   arpre_ram #(.WIDTH(PEND_W), .DEPTH(arpre_pkg::PENDING_ENTRIES), .AW(arpre_pkg::PEND_AW))
   u_pend_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rd_bits)
   );

   arpre_ram #(.WIDTH(WAIT_W), .DEPTH(arpre_pkg::WAIT_DEPTH), .AW(arpre_pkg::WAIT_AW))
   u_wait_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (w_raddr),
      .rd_data (w_rd_bits)
   );

   always_comb begin
      cfree_vld = 1'b0;
      cfree_idx = '0;
      for (int i = arpre_pkg::CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (!cache_vld_ff[i]) begin
            cfree_vld = 1'b1;
            cfree_idx = arpre_pkg::CACHE_AW'(i);
         end
      end
      pfree_vld = 1'b0;
      pfree_idx = '0;
      for (int i = arpre_pkg::PENDING_ENTRIES - 1; i >= 0; i--) begin
         if (!pend_vld_ff[i]) begin
            pfree_vld = 1'b1;
            pfree_idx = arpre_pkg::PEND_AW'(i);
         end
      end
   end

   assign el_ext   = arpre_pkg::TTL_W'(item_ff.elapsed_ms);
   assign dst_ok   = (item_ff.frame_dst_mac == own_mac_ff) ||
                     (item_ff.frame_dst_mac == arpre_pkg::BCAST_MAC);
   assign is_req   = (item_ff.arp_opcode == arpre_pkg::ARP_OP_REQUEST) &&
                     (item_ff.arp_target_ip == own_ip_ff);
   assign wait_end = ((arpre_pkg::CNT_W'(idx_ff) + arpre_pkg::CNT_W'(1)) ==
                      arpre_pkg::CNT_W'(wait_cnt_ff));
   assign can_emit = !hold_vld_ff || !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      item_load    = 1'b0;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      min_ttl_in   = min_ttl_ff;
      min_idx_in   = min_idx_ff;
      wr_ptr_in    = wr_ptr_ff;
      wait_cnt_in  = wait_cnt_ff;
      cache_vld_in = cache_vld_ff;
      pend_vld_in  = pend_vld_ff;
      emit_en      = 1'b0;
      emit_data    = '0;
      fin_push     = 1'b0;
      c_we         = 1'b0;
      c_waddr      = c_raddr;
      c_wdata      = c_rd;
      p_we         = 1'b0;
      p_waddr      = p_raddr;
      p_wdata      = p_rd;
      w_we         = 1'b0;
      w_waddr      = w_raddr;
      w_wdata      = w_rd;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_load = 1'b1;
               state_in  = ST_DEC;
            end
         end

         ST_DEC: begin
            idx_in   = '0;
            phase_in = 1'b0;
            match_in = 1'b0;
            state_in = ST_FINISH;
            case (item_ff.op)
               arpre_pkg::OP_SEND: state_in = ST_S_CSCAN;
               arpre_pkg::OP_TICK: state_in = ST_T_CSCAN;
               arpre_pkg::OP_RECEIVE: begin
                  if (dst_ok && item_ff.parse_ok) begin
                     if (item_ff.frame_type == arpre_pkg::FTYPE_IPV4) begin
                        emit_en             = 1'b1;
                        emit_data.out_kind  = arpre_pkg::KIND_DELIVER;
                        emit_data.dgram_out = item_ff.dgram_handle;
                     end else if (item_ff.frame_type == arpre_pkg::FTYPE_ARP) begin
                        if (is_req) begin
                           emit_en                     = 1'b1;
                           emit_data.out_kind          = arpre_pkg::KIND_ARP_REPLY;
                           emit_data.dst_mac           = item_ff.arp_sender_mac;
                           emit_data.arp_target_mac    = item_ff.arp_sender_mac;
                           emit_data.arp_target_ip_out = item_ff.arp_sender_ip;
                        end
                        if (is_req || (item_ff.arp_opcode == arpre_pkg::ARP_OP_REPLY)) begin
                           state_in = ST_L_CSCAN;
                        end
                     end
                  end
               end
               default: state_in = ST_FINISH;
            endcase
         end

         ST_S_CSCAN: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else if (cache_vld_ff[c_raddr] && (c_rd.ip == item_ff.hop_ip)) begin
               if (can_emit) begin
                  emit_en             = 1'b1;
                  emit_data.out_kind  = arpre_pkg::KIND_IPV4_OUT;
                  emit_data.dst_mac   = c_rd.mac;
                  emit_data.dgram_out = item_ff.dgram_handle;
                  state_in            = ST_FINISH;
               end
            end else begin
               phase_in = 1'b0;
               if (idx_ff == CACHE_LAST) begin
                  idx_in   = '0;
                  state_in = ST_S_PSCAN;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_S_PSCAN: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (pend_vld_ff[p_raddr] && (p_rd.ip == item_ff.hop_ip)) begin
                  match_in = 1'b1;
                  state_in = ST_S_ALLOC;
               end else if (idx_ff == PEND_LAST) begin
                  state_in = ST_S_ALLOC;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_S_ALLOC: begin
            if (!(!match_ff && pfree_vld && !can_emit)) begin
               if (!match_ff && pfree_vld) begin
                  p_we                        = 1'b1;
                  p_waddr                     = pfree_idx;
                  p_wdata.ip                  = item_ff.hop_ip;
                  p_wdata.timer               = retry_ff;
                  pend_vld_in[pfree_idx]      = 1'b1;
                  emit_en                     = 1'b1;
                  emit_data.out_kind          = arpre_pkg::KIND_ARP_REQUEST;
                  emit_data.dst_mac           = arpre_pkg::BCAST_MAC;
                  emit_data.arp_target_ip_out = item_ff.hop_ip;
               end
               if (wait_cnt_ff != WAIT_FULL) begin
                  w_we           = 1'b1;
                  w_waddr        = wait_cnt_ff[arpre_pkg::WAIT_AW-1:0];
                  w_wdata.ip     = item_ff.hop_ip;
                  w_wdata.handle = item_ff.dgram_handle;
                  wait_cnt_in    = wait_cnt_ff + 1'b1;
               end
               state_in = ST_FINISH;
            end
         end

         ST_L_CSCAN: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (!match_ff && cache_vld_ff[c_raddr] &&
                   (c_rd.ip == item_ff.arp_sender_ip)) begin
                  match_in     = 1'b1;
                  match_idx_in = c_raddr;
               end
               if ((idx_ff == '0) || (c_rd.ttl < min_ttl_ff)) begin
                  min_ttl_in = c_rd.ttl;
                  min_idx_in = c_raddr;
               end
               if (idx_ff == CACHE_LAST) begin
                  state_in = ST_L_CWR;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_L_CWR: begin
            c_we = 1'b1;
            if (match_ff) begin
               c_waddr = match_idx_ff;
            end else if (cfree_vld) begin
               c_waddr = cfree_idx;
            end else begin
               c_waddr = min_idx_ff;
            end
            c_wdata.ip            = item_ff.arp_sender_ip;
            c_wdata.mac           = item_ff.arp_sender_mac;
            c_wdata.ttl           = lifetime_ff;
            cache_vld_in[c_waddr] = 1'b1;
            idx_in                = '0;
            phase_in              = 1'b0;
            wr_ptr_in             = '0;
            state_in              = (wait_cnt_ff == '0) ? ST_F_PCLR : ST_F_WSCAN;
         end

         ST_F_WSCAN: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else if (!((w_rd.ip == item_ff.arp_sender_ip) && !can_emit)) begin
               phase_in = 1'b0;
               if (w_rd.ip == item_ff.arp_sender_ip) begin
                  emit_en             = 1'b1;
                  emit_data.out_kind  = arpre_pkg::KIND_IPV4_OUT;
                  emit_data.dst_mac   = item_ff.arp_sender_mac;
                  emit_data.dgram_out = w_rd.handle;
               end else begin
                  w_we      = 1'b1;
                  w_waddr   = wr_ptr_ff[arpre_pkg::WAIT_AW-1:0];
                  wr_ptr_in = wr_ptr_ff + 1'b1;
               end
               if (wait_end) begin
                  wait_cnt_in = wr_ptr_in;
                  idx_in      = '0;
                  state_in    = ST_F_PCLR;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_F_PCLR: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (pend_vld_ff[p_raddr] && (p_rd.ip == item_ff.arp_sender_ip)) begin
                  pend_vld_in[p_raddr] = 1'b0;
                  state_in             = ST_FINISH;
               end else if (idx_ff == PEND_LAST) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_T_CSCAN: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (cache_vld_ff[c_raddr]) begin
                  if (c_rd.ttl <= el_ext) begin
                     cache_vld_in[c_raddr] = 1'b0;
                  end else begin
                     c_we        = 1'b1;
                     c_wdata.ttl = c_rd.ttl - el_ext;
                  end
               end
               if (idx_ff == CACHE_LAST) begin
                  idx_in   = '0;
                  state_in = ST_T_PSCAN;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_T_PSCAN: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else if (!(pend_vld_ff[p_raddr] && (p_rd.timer <= el_ext) && !can_emit)) begin
               phase_in = 1'b0;
               if (pend_vld_ff[p_raddr]) begin
                  p_we = 1'b1;
                  if (p_rd.timer <= el_ext) begin
                     p_wdata.timer               = retry_ff;
                     emit_en                     = 1'b1;
                     emit_data.out_kind          = arpre_pkg::KIND_ARP_REQUEST;
                     emit_data.dst_mac           = arpre_pkg::BCAST_MAC;
                     emit_data.arp_target_ip_out = p_rd.ip;
                  end else begin
                     p_wdata.timer = p_rd.timer - el_ext;
                  end
               end
               if (idx_ff == PEND_LAST) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_FINISH: begin
            if (!hold_vld_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               fin_push = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // held result moves out, marked last only when the item is done
   always_comb begin
      push_data      = hold_ff;
      push_data.last = fin_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         phase_ff     <= 1'b0;
         match_ff     <= 1'b0;
         wr_ptr_ff    <= '0;
         wait_cnt_ff  <= '0;
         cache_vld_ff <= '0;
         pend_vld_ff  <= '0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         own_mac_ff   <= '0;
         own_ip_ff    <= '0;
         lifetime_ff  <= arpre_pkg::LIFETIME_RESET;
         retry_ff     <= arpre_pkg::RETRY_RESET;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         match_ff     <= match_in;
         wr_ptr_ff    <= wr_ptr_in;
         wait_cnt_ff  <= wait_cnt_in;
         cache_vld_ff <= cache_vld_in;
         pend_vld_ff  <= pend_vld_in;
         if (emit_en) begin
            hold_vld_ff <= 1'b1;
         end else if (fin_push) begin
            hold_vld_ff <= 1'b0;
         end
         if ((emit_en && hold_vld_ff) || fin_push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               arpre_pkg::CSR_OWN_MAC:  own_mac_ff  <= csr_wdata;
               arpre_pkg::CSR_OWN_IP:   own_ip_ff   <= csr_wdata[arpre_pkg::IP_W-1:0];
               arpre_pkg::CSR_LIFETIME: lifetime_ff <= csr_wdata[arpre_pkg::TTL_W-1:0];
               arpre_pkg::CSR_RETRY:    retry_ff    <= csr_wdata[arpre_pkg::TTL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_load) begin
         item_ff <= req_data;
      end
      match_idx_ff <= match_idx_in;
      min_ttl_ff   <= min_ttl_in;
      min_idx_ff   <= min_idx_in;
      if (emit_en) begin
         hold_ff <= emit_data;
      end
      if ((emit_en && hold_vld_ff) || fin_push) begin
         rsp_data_ff <= push_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ARPRE_ASSERT_IMP(a_idle_hold_empty, req_ready, !hold_vld_ff)
   `ARPRE_ASSERT_NXT(a_accept_leaves_idle, req_valid && req_ready, state_ff == ST_DEC)
   `ARPRE_ASSERT_IMP(a_wait_cnt_bound, 1'b1, wait_cnt_ff <= WAIT_FULL)
   `ARPRE_ASSERT_IMP(a_emit_has_room, emit_en && hold_vld_ff, !rsp_valid_ff || rsp_ready)

endmodule

// ----- rtl/core/arpre_ram.sv -----
// ----------------------------------------------------------------------------
// arpre_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
